// File: hw/rtl/sorted_table_binary_search_unit_macros.svh
// assertion macros for the search unit rtl
`ifndef SORTED_TABLE_BINARY_SEARCH_UNIT_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_UNIT_MACROS_SVH

// checked on every clock edge outside reset
`define STBS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// checked on every clock edge, reset included
`define STBS_ASSERT_NR(label, prop, msg) \
	label: assert property (@(posedge clk) prop) \
	else $error(msg);

`endif

// File: hw/rtl/stbs_pkg.sv
// shared types and constants of the sorted table search unit
package stbs_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 1024;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned COUNT_W = 11;
	localparam int unsigned INDEX_W = 10;

	localparam logic ACTION_WRITE  = 1'b0;
	localparam logic ACTION_SEARCH = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_FINISH
	} stbs_state_t;

	// search request handed from the front end to the controller
	typedef struct packed {
		logic               search_go;
		logic [VALUE_W-1:0] key;
	} stbs_req_t;

endpackage

// File: hw/rtl/stbs_ram.sv
// generic single write port ram with a registered read port
module stbs_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/stbs_search.sv
// halving search controller: bounds, probe addresses and the result register
`include "sorted_table_binary_search_unit_macros.svh"

module stbs_search import stbs_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  stbs_req_t                                         req,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0]                  eff_count,
	output logic                                              in_ready,
	output logic                                              rd_en,
	output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] rd_addr,
	input  logic [VALUE_W-1:0]                                rd_data,
	output logic                                              out_valid,
	input  logic                                              out_ready,
	output logic                                              found
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned BW = $clog2(TABLE_DEPTH + 1);

	stbs_state_t state_q, state_d;

	logic [BW-1:0]      low_q, high_q, mid_q;
	logic [VALUE_W-1:0] key_q;
	logic               hit_q;
	logic               out_valid_q, found_q;

	logic          rd_eq, rd_lt;
	logic [BW-1:0] nlow, nhigh, nmid, init_mid;
	logic          more;
	logic          out_load;

	// compare the probed entry and narrow the half-open range
	always_comb begin
		rd_eq    = (rd_data == key_q);
		rd_lt    = ($signed(rd_data) < $signed(key_q));
		nlow     = rd_lt ? (mid_q + BW'(1)) : low_q;
		nhigh    = rd_lt ? high_q : mid_q;
		nmid     = nlow + ((nhigh - nlow) >> 1);
		init_mid = eff_count >> 1;
		more     = !rd_eq && (nlow < nhigh);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.search_go) begin
					state_d = (eff_count == '0) ? ST_FINISH : ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!more) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = init_mid[AW-1:0];
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				rd_en    = req.search_go && (eff_count != '0);
				rd_addr  = init_mid[AW-1:0];
			end
			ST_CHECK: begin
				rd_en   = more;
				rd_addr = nmid[AW-1:0];
			end
			ST_FINISH: begin
				out_load = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.search_go) begin
			key_q  <= req.key;
			low_q  <= '0;
			high_q <= eff_count;
			mid_q  <= init_mid;
			hit_q  <= 1'b0;
		end else if (state_q == ST_CHECK) begin
			low_q  <= nlow;
			high_q <= nhigh;
			mid_q  <= nmid;
			hit_q  <= rd_eq;
		end
		if (out_load) begin
			found_q <= hit_q;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;

	`STBS_ASSERT(a_probe_in_range, (state_q == ST_CHECK) |-> (low_q <= mid_q && mid_q < high_q), "probe outside search range")
	`STBS_ASSERT(a_bound_in_table, (state_q == ST_CHECK) |-> (high_q <= BW'(TABLE_DEPTH)), "upper bound past table")
	`STBS_ASSERT(a_range_shrinks, (state_q == ST_CHECK && $past(state_q) == ST_CHECK) |-> ((high_q - low_q) < $past(high_q - low_q)), "search range did not shrink")
	`STBS_ASSERT(a_result_held, (state_q == ST_FINISH && out_valid_q && !out_ready) |=> (state_q == ST_FINISH && out_valid_q), "pending result overwritten")
	`STBS_ASSERT_NR(a_reset_idle, !arst_n |-> (state_q == ST_IDLE && !out_valid_q), "not idle in reset")

endmodule

// File: hw/rtl/sorted_table_binary_search_unit.sv
// write item: written into the table at accept, no result beat
// search item: first probe issued at accept (none if the count is zero), then one ram read and compare per cycle,
// at most floor(log2(count)) + 1 probes, then the result goes into the result register
// no new item is accepted until a search's result has been loaded into the result register
// the table ram is not cleared at reset, only entry_count and control state reset
module sorted_table_binary_search_unit import stbs_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      action,
	input  logic [INDEX_W-1:0]        entry_index,
	input  logic signed [VALUE_W-1:0] entry_value,
	input  logic signed [VALUE_W-1:0] search_key,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      found,
	input  logic                      cfg_we,
	input  logic [COUNT_W-1:0]        cfg_wdata
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned BW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned CW = (BW > COUNT_W) ? BW : COUNT_W;
	localparam int unsigned IW = (BW > INDEX_W) ? BW : INDEX_W;

	logic [COUNT_W-1:0] entry_count_q;
	logic [CW-1:0]      cnt_ext;
	logic [BW-1:0]      eff_count;
	logic [IW-1:0]      idx_ext;
	logic               in_fire;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [VALUE_W-1:0] rd_data;
	stbs_req_t          req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_we) begin
			entry_count_q <= cfg_wdata;
		end
	end

	// count saturates at the table depth
	always_comb begin
		cnt_ext   = CW'(entry_count_q);
		eff_count = (cnt_ext > CW'(TABLE_DEPTH)) ? BW'(TABLE_DEPTH) : BW'(cnt_ext);
	end

	always_comb begin
		in_fire       = in_valid && in_ready;
		idx_ext       = IW'(entry_index);
		wr_en         = in_fire && (action == ACTION_WRITE) && (idx_ext < IW'(TABLE_DEPTH));
		wr_addr       = AW'(idx_ext);
		req.search_go = in_fire && (action == ACTION_SEARCH);
		req.key       = search_key;
	end

	stbs_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (entry_value),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	stbs_search #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.eff_count (eff_count),
		.in_ready  (in_ready),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.found     (found)
	);

endmodule
